// ===== src/dtve_pkg.sv =====
package dtve_pkg;

  localparam int unsigned PreambleLen  = 132;
  localparam int unsigned ShortHdrLen  = 8;
  localparam int unsigned LongLenBytes = 4;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrBits  = 2;
  localparam int unsigned FifoCntBits  = 3;

  localparam logic [15:0] ResetTargetGroup   = 16'h7FE0;
  localparam logic [15:0] ResetTargetElement = 16'h0010;

  // register indexes on the configuration port
  localparam logic REG_TAG_GROUP   = 1'b0;
  localparam logic REG_TAG_ELEMENT = 1'b1;

  // VR characters that take a 32-bit length
  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChF = 8'h46;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChQ = 8'h51;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChU = 8'h55;
  localparam logic [7:0] ChW = 8'h57;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_HEADER   = 3'd1,
    PH_LONGLEN  = 3'd2,
    PH_VALUE    = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MS_NONE   = 2'd0,
    MS_FOUND  = 2'd1,
    MS_ACTIVE = 2'd2
  } match_t;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  value_byte;
    logic [1:0]  search_status;
    logic [31:0] value_offset;
    logic        last_of_run;
  } out_t;

  // results produced by one accepted byte, packed from first
  typedef struct packed {
    logic [1:0] n;
    out_t       first;
    out_t       second;
  } push_t;

  function automatic logic is_long_vr(input logic [7:0] a, input logic [7:0] b);
    logic r;
    r = 1'b0;
    if (a == ChO && (b == ChB || b == ChW || b == ChF)) r = 1'b1;
    if (a == ChS && b == ChQ) r = 1'b1;
    if (a == ChU && (b == ChT || b == ChN)) r = 1'b1;
    return r;
  endfunction

endpackage

// ===== src/dtve_parser.sv =====
module dtve_parser #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            accept,
  input  dtve_pkg::in_t   in_data,
  output dtve_pkg::push_t push
);
  import dtve_pkg::*;

  logic [15:0] tag_group;
  logic [15:0] tag_element;

  logic [POSITION_BITS-1:0] file_position, file_position_next;
  phase_t      parse_phase, parse_phase_next;
  logic [63:0] header_bytes, header_bytes_next;
  logic [31:0] long_length_bytes, long_length_bytes_next;
  logic [3:0]  header_count, header_count_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  match_t      match_state, match_state_next;
  logic [31:0] match_offset, match_offset_next;

  logic [63:0] hdr_new;
  logic [31:0] long_new;
  logic [5:0]  hdr_sel;
  logic [4:0]  long_sel;
  logic        sv_go;
  logic [31:0] sv_len;
  logic        hit;
  out_t        val_item;
  out_t        stat_item;

  assign hdr_sel  = {header_count[2:0], 3'b000};
  assign long_sel = {header_count[1:0], 3'b000};

  always_comb begin
    hdr_new = header_bytes;
    hdr_new[hdr_sel +: 8] = in_data.data_byte;
    long_new = long_length_bytes;
    long_new[long_sel +: 8] = long_length_bytes[long_sel +: 8] | in_data.data_byte;
  end

  always_comb begin
    file_position_next     = (file_position != '1) ?
                             file_position + POSITION_BITS'(1) : file_position;
    parse_phase_next       = parse_phase;
    header_bytes_next      = header_bytes;
    long_length_bytes_next = long_length_bytes;
    header_count_next      = header_count;
    bytes_remaining_next   = bytes_remaining;
    match_state_next       = match_state;
    match_offset_next      = match_offset;
    sv_go    = 1'b0;
    sv_len   = '0;
    hit      = 1'b0;
    val_item = '0;
    push     = '0;

    case (parse_phase)
      PH_PREAMBLE: begin
        if (file_position_next >= POSITION_BITS'(PreambleLen)) begin
          parse_phase_next  = PH_HEADER;
          header_count_next = '0;
        end
      end
      PH_HEADER: begin
        header_bytes_next = hdr_new;
        header_count_next = header_count + 4'd1;
        if (header_count == 4'(ShortHdrLen - 1)) begin
          if (is_long_vr(hdr_new[39:32], hdr_new[47:40])) begin
            header_count_next      = '0;
            long_length_bytes_next = '0;
            parse_phase_next       = PH_LONGLEN;
          end else begin
            sv_go  = 1'b1;
            sv_len = {16'd0, hdr_new[63:48]};
          end
        end
      end
      PH_LONGLEN: begin
        long_length_bytes_next = long_new;
        header_count_next      = header_count + 4'd1;
        if (header_count == 4'(LongLenBytes - 1)) begin
          sv_go  = 1'b1;
          sv_len = long_new;
        end
      end
      PH_VALUE: begin
        if (match_state == MS_ACTIVE) begin
          val_item.item_kind   = KIND_VALUE;
          val_item.value_byte  = in_data.data_byte;
          val_item.last_of_run = ~in_data.final_byte;
          push.n     = 2'd1;
          push.first = val_item;
        end
        bytes_remaining_next = bytes_remaining - 32'd1;
        if (bytes_remaining == 32'd1) begin
          if (match_state == MS_ACTIVE) begin
            match_state_next = MS_FOUND;
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next  = PH_HEADER;
            header_count_next = '0;
          end
        end
      end
      default: ;
    endcase

    // element header complete: compare tag and pick the next phase
    if (sv_go) begin
      hit = (header_bytes_next[15:0] == tag_group) &&
            (header_bytes_next[31:16] == tag_element);
      header_count_next = '0;
      if (hit) begin
        match_offset_next = 32'(file_position_next);
        if (sv_len == 32'd0) begin
          match_state_next = MS_FOUND;
          parse_phase_next = PH_DONE;
        end else begin
          match_state_next     = MS_ACTIVE;
          bytes_remaining_next = sv_len;
          parse_phase_next     = PH_VALUE;
        end
      end else if (sv_len == 32'd0) begin
        parse_phase_next = PH_HEADER;
      end else begin
        bytes_remaining_next = sv_len;
        parse_phase_next     = PH_VALUE;
      end
    end

    stat_item = '0;
    stat_item.item_kind     = KIND_STATUS;
    stat_item.search_status = match_state_next;
    stat_item.value_offset  = (match_state_next != MS_NONE) ? match_offset_next : 32'd0;
    stat_item.last_of_run   = 1'b1;

    if (in_data.final_byte) begin
      if (push.n == 2'd1) begin
        push.second = stat_item;
        push.n      = 2'd2;
      end else begin
        push.first = stat_item;
        push.n     = 2'd1;
      end
      // end of file: back to a fresh parse
      file_position_next     = '0;
      parse_phase_next       = PH_PREAMBLE;
      header_bytes_next      = '0;
      long_length_bytes_next = '0;
      header_count_next      = '0;
      bytes_remaining_next   = '0;
      match_state_next       = MS_NONE;
      match_offset_next      = '0;
    end

    if (!accept) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_group         <= ResetTargetGroup;
      tag_element       <= ResetTargetElement;
      file_position     <= '0;
      parse_phase       <= PH_PREAMBLE;
      header_bytes      <= '0;
      long_length_bytes <= '0;
      header_count      <= '0;
      bytes_remaining   <= '0;
      match_state       <= MS_NONE;
      match_offset      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TAG_GROUP:   tag_group   <= cfg_data;
          REG_TAG_ELEMENT: tag_element <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        file_position     <= file_position_next;
        parse_phase       <= parse_phase_next;
        header_bytes      <= header_bytes_next;
        long_length_bytes <= long_length_bytes_next;
        header_count      <= header_count_next;
        bytes_remaining   <= bytes_remaining_next;
        match_state       <= match_state_next;
        match_offset      <= match_offset_next;
      end
    end
  end

endmodule

// ===== src/dtve_result_fifo.sv =====
module dtve_result_fifo (
  input  logic            clk,
  input  logic            rst,
  input  dtve_pkg::push_t push,
  input  logic            pop,
  output logic            not_empty,
  output logic            nearly_full,
  output dtve_pkg::out_t  head
);
  import dtve_pkg::*;

  out_t                   mem [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr, rd_ptr;
  logic [FifoCntBits-1:0] count, count_next;
  logic [FifoPtrBits-1:0] wr_ptr_1;

  assign wr_ptr_1    = wr_ptr + FifoPtrBits'(1);
  assign not_empty   = (count != '0);
  // fewer than two free slots: a final byte could not be taken
  assign nearly_full = (count > FifoCntBits'(FifoDepth - 2));
  assign head        = mem[rd_ptr];
  assign count_next  = count + FifoCntBits'(push.n) - FifoCntBits'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.first;
    if (push.n == 2'd2) mem[wr_ptr_1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FifoPtrBits'(push.n);
      if (pop) rd_ptr <= rd_ptr + FifoPtrBits'(1);
      count <= count_next;
    end
  end

endmodule

// ===== src/dicom_tag_value_extractor.sv =====
// Results from an accepted byte are written into the result queue; out_data shows the queue head.
// Throughput: one byte per cycle while in_stall is low; the parse state updates in the accepting cycle.
// The final byte can give two results; a 4-entry result queue absorbs them and
// in_stall is raised while fewer than two queue slots are free.
// Reset (rst, synchronous): parse state and queue cleared, tag set to 7FE0,0010.
module dicom_tag_value_extractor #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  dtve_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dtve_pkg::out_t out_data
);
  import dtve_pkg::*;

  push_t push;
  logic  accept;
  logic  pop;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  dtve_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_data   (in_data),
    .push      (push)
  );

  dtve_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pop         (pop),
    .not_empty   (out_valid),
    .nearly_full (in_stall),
    .head        (out_data)
  );

endmodule

// ===== src/dtve_checker.sv =====
module dtve_checker (
  input logic           clk,
  input logic           rst,
  input logic           cfg_write,
  input logic           cfg_index,
  input logic [15:0]    cfg_data,
  input logic           in_valid,
  input logic           in_stall,
  input dtve_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input dtve_pkg::out_t out_data
);
  import dtve_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // input back-pressure only comes from queued results
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result queue");

endmodule

bind dicom_tag_value_extractor dtve_checker u_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dtve_pkg::*;

  // position counter width given to the block under test
  localparam int PosBits = 16;
  localparam int QuietLimit = 5000;
  localparam int PhaseBytes = 100;

  typedef struct packed {
    logic [15:0] tgt_grp;
    logic [15:0] tgt_elm;
    logic        lead;    // non-matching element ahead of the one under test
    logic [15:0] grp;
    logic [15:0] elm;
    logic [15:0] vr;
    logic [31:0] len;     // declared value length
    logic [31:0] sent;    // value bytes actually sent
    logic [7:0]  tail;    // junk bytes after the value
    logic [15:0] cut;     // file length cap, 0 for none
    match_t      status;
    logic [31:0] offset;
  } file_case_t;

  typedef struct packed {
    bit          typed;
    logic [1:0]  status;
    logic [31:0] offset;
  } status_note_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_TAG_GROUP;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int unsigned in_gap_pct = 0;
  int unsigned out_gap_pct = 0;
  int unsigned sent_count = 0;
  int unsigned mismatches = 0;

  out_t results_due [$];
  status_note_t status_notes [$];
  logic [7:0] file_bytes [$];

  logic [15:0] wide_vrs [6] = '{"OB", "OW", "OF", "SQ", "UT", "UN"};
  logic [15:0] short_vrs [6] = '{"US", "UI", "LO", "OA", "SS", "UC"};

  // target tag, lead, element tag, vr, len, sent, tail, cut, expected status and offset
  file_case_t plan [16] = '{
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "US", 4, 4, 0, 1, MS_NONE, 0},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "US", 4, 4, 0, 132, MS_NONE, 0},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "US", 4, 4, 0, 137, MS_NONE, 0},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "US", 4, 4, 0, 0, MS_FOUND, 140},
    '{16'h7FE0, 16'h0010, 1, 16'h7FE0, 16'h0010, "OB", 3, 3, 3, 0, MS_FOUND, 154},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "OW", 0, 0, 2, 0, MS_FOUND, 144},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "OF", 5, 2, 0, 0, MS_ACTIVE, 144},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0011, "SQ", 6, 3, 0, 0, MS_NONE, 0},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "UT", 'hFFFF_FFFF, 4, 0, 0,
      MS_ACTIVE, 144},
    '{16'h7FE0, 16'h0010, 1, 16'h7FE0, 16'h0010, "UN", 2, 2, 12, 0, MS_FOUND, 154},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "OA", 2, 2, 0, 0, MS_FOUND, 140},
    '{16'h7FE0, 16'h0010, 0, 16'h7FE0, 16'h0010, "SS", 1, 1, 1, 0, MS_FOUND, 140},
    '{16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, "UC", 2, 2, 0, 0, MS_FOUND, 140},
    '{16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, "OB", 1, 1, 0, 0, MS_FOUND, 154},
    '{16'h0000, 16'h0000, 0, 16'h0000, 16'h0001, "US", 2, 2, 3, 0, MS_NONE, 0},
    '{16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, "OB", 8, 8, 0, 152, MS_NONE, 0}
  };

  dicom_tag_value_extractor #(.POSITION_BITS(PosBits)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- parser model
  logic [15:0]        tgt_grp, tgt_elm;
  logic [PosBits-1:0] m_pos, m_moff;
  phase_t             m_phase;
  logic [7:0]         m_hdr [8];
  logic [31:0]        m_llen;
  logic [3:0]         m_cnt;
  logic [31:0]        m_left;
  match_t             m_match;

  function automatic void clear_file();
    m_pos = '0;
    m_phase = PH_PREAMBLE;
    m_hdr = '{default: 8'h00};
    m_llen = '0;
    m_cnt = '0;
    m_left = '0;
    m_match = MS_NONE;
    m_moff = '0;
  endfunction

  function automatic bit wide_len_vr(input logic [7:0] a, input logic [7:0] b);
    return (a == "O" && (b == "B" || b == "W" || b == "F")) || (a == "S" && b == "Q") ||
           (a == "U" && (b == "T" || b == "N"));
  endfunction

  function automatic void open_value(input logic [31:0] len, input logic [PosBits-1:0] at);
    logic hit;
    hit = ({m_hdr[1], m_hdr[0]} == tgt_grp) && ({m_hdr[3], m_hdr[2]} == tgt_elm);
    m_cnt = '0;
    if (hit) begin
      m_moff = at;
      if (len == 0) begin
        m_match = MS_FOUND;
        m_phase = PH_DONE;
      end else begin
        m_match = MS_ACTIVE;
        m_left = len;
        m_phase = PH_VALUE;
      end
    end else if (len == 0) begin
      m_phase = PH_HEADER;
    end else begin
      m_left = len;
      m_phase = PH_VALUE;
    end
  endfunction

  // advance the model by one accepted request, queue what it should produce
  function automatic void parse_byte(input in_t d);
    logic [PosBits-1:0] nxt;
    out_t r;
    status_note_t note;
    nxt = (m_pos == '1) ? m_pos : m_pos + PosBits'(1);
    m_pos = nxt;
    case (m_phase)
      PH_PREAMBLE: begin
        if (nxt >= PreambleLen) begin
          m_phase = PH_HEADER;
          m_cnt = '0;
        end
      end
      PH_HEADER: begin
        m_hdr[m_cnt[2:0]] = d.data_byte;
        m_cnt++;
        if (m_cnt >= ShortHdrLen) begin
          if (wide_len_vr(m_hdr[4], m_hdr[5])) begin
            m_cnt = '0;
            m_llen = '0;
            m_phase = PH_LONGLEN;
          end else begin
            open_value({16'h0000, m_hdr[7], m_hdr[6]}, nxt);
          end
        end
      end
      PH_LONGLEN: begin
        m_llen[m_cnt[1:0] * 8 +: 8] = d.data_byte;
        m_cnt++;
        if (m_cnt >= LongLenBytes) open_value(m_llen, nxt);
      end
      PH_VALUE: begin
        if (m_match == MS_ACTIVE) begin
          r = '0;
          r.item_kind = KIND_VALUE;
          r.value_byte = d.data_byte;
          r.last_of_run = !d.final_byte;
          results_due.insert(results_due.size(), r);
        end
        m_left--;
        if (m_left == 0) begin
          if (m_match == MS_ACTIVE) begin
            m_match = MS_FOUND;
            m_phase = PH_DONE;
          end else begin
            m_phase = PH_HEADER;
            m_cnt = '0;
          end
        end
      end
      default: ;
    endcase
    if (d.final_byte) begin
      note = '0;
      if (status_notes.size() != 0) note = status_notes.pop_front();
      r = '0;
      r.item_kind = KIND_STATUS;
      r.search_status = m_match;
      r.value_offset = (m_match != MS_NONE) ? 32'(m_moff) : 32'h0;
      r.last_of_run = 1'b1;
      if (note.typed) begin
        r.search_status = note.status;
        r.value_offset = note.offset;
      end
      results_due.insert(results_due.size(), r);
      clear_file();
    end
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string line);
    $display("%0t mismatch: %s", $time, line);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    out_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, kind %0h byte %0h",
                                out_data.item_kind, out_data.value_byte));
    end else begin
      want = results_due.pop_front();
      check_field("item_kind", 32'(out_data.item_kind), 32'(want.item_kind));
      check_field("value_byte", 32'(out_data.value_byte), 32'(want.value_byte));
      check_field("search_status", 32'(out_data.search_status), 32'(want.search_status));
      check_field("value_offset", out_data.value_offset, want.value_offset);
      check_field("last_of_run", 32'(out_data.last_of_run), 32'(want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) parse_byte(in_data);
      if (out_valid && !out_stall) check_result();
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < out_gap_pct);

  // ---------------------------------------------------------------- stimulus
  function automatic void put_hdr(input logic [15:0] g, input logic [15:0] e,
                                  input logic [15:0] vr, input logic [31:0] len);
    file_bytes.insert(file_bytes.size(), g[7:0]);
    file_bytes.insert(file_bytes.size(), g[15:8]);
    file_bytes.insert(file_bytes.size(), e[7:0]);
    file_bytes.insert(file_bytes.size(), e[15:8]);
    file_bytes.insert(file_bytes.size(), vr[15:8]);
    file_bytes.insert(file_bytes.size(), vr[7:0]);
    if (wide_len_vr(vr[15:8], vr[7:0])) begin
      file_bytes.insert(file_bytes.size(), 8'($urandom));
      file_bytes.insert(file_bytes.size(), 8'($urandom));
      for (int i = 0; i < 4; i++) file_bytes.insert(file_bytes.size(), len[i * 8 +: 8]);
    end else begin
      file_bytes.insert(file_bytes.size(), len[7:0]);
      file_bytes.insert(file_bytes.size(), len[15:8]);
    end
  endfunction

  function automatic void put_junk(input int unsigned n);
    repeat (n) file_bytes.insert(file_bytes.size(), 8'($urandom));
  endfunction

  function automatic void build_case(input file_case_t c);
    file_bytes.delete();
    put_junk(PreambleLen);
    if (c.lead) begin
      put_hdr(16'h0008, 16'h0016, "UI", 2);
      put_junk(2);
    end
    put_hdr(c.grp, c.elm, c.vr, c.len);
    put_junk(c.sent);
    put_junk(32'(c.tail));
    if (c.cut != 0) begin
      while (file_bytes.size() > c.cut) void'(file_bytes.pop_back());
    end
  endfunction

  function automatic void build_random_file();
    int unsigned n_el;
    int unsigned pick;
    logic [15:0] g, e, vr;
    logic [31:0] len;
    file_bytes.delete();
    if ($urandom_range(9) == 0) begin
      put_junk($urandom_range(1, 300));
      return;
    end
    put_junk(PreambleLen);
    n_el = $urandom_range(0, 6);
    for (int k = 0; k < n_el; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          g = tgt_grp;
          e = tgt_elm;
        end
        4, 5: begin
          g = tgt_grp;
          e = tgt_elm ^ (16'h1 << $urandom_range(15));
        end
        6: begin
          g = tgt_grp ^ (16'h1 << $urandom_range(15));
          e = tgt_elm;
        end
        default: begin
          g = 16'($urandom);
          e = 16'($urandom);
        end
      endcase
      pick = $urandom_range(19);
      if (pick < 12) vr = wide_vrs[$urandom_range(5)];
      else if (pick < 18) vr = short_vrs[$urandom_range(5)];
      else vr = 16'($urandom);
      pick = $urandom_range(9);
      if (pick < 7) len = $urandom_range(0, 8);
      else if (pick < 9) len = $urandom_range(9, 40);
      else len = $urandom;
      if (!wide_len_vr(vr[15:8], vr[7:0])) len = {16'h0000, len[15:0]};
      put_hdr(g, e, vr, len);
      // a long value ends the file part way through
      if (len > 40) begin
        put_junk($urandom_range(0, 20));
        return;
      end
      put_junk(len);
    end
    if ($urandom_range(3) == 0) begin
      len = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > len) void'(file_bytes.pop_back());
    end else begin
      put_junk($urandom_range(0, 3));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, final_byte: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // hold the sender until every queued result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_file(input status_note_t note);
    int unsigned hold_at;
    hold_at = file_bytes.size();
    if ($urandom_range(9) == 0) hold_at = $urandom_range(0, file_bytes.size() - 1);
    status_notes.insert(status_notes.size(), note);
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i == hold_at) drain();
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  task automatic write_tag(input logic [15:0] g, input logic [15:0] e);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_TAG_GROUP;
    cfg_data <= g;
    @(posedge clk);
    tgt_grp = g;
    cfg_index <= REG_TAG_ELEMENT;
    cfg_data <= e;
    @(posedge clk);
    tgt_elm = e;
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned goal;
    int unsigned in_gaps [3];
    int unsigned out_gaps [3];
    in_gaps = '{34, 70, 0};
    out_gaps = '{70, 34, 0};
    tgt_grp = ResetTargetGroup;
    tgt_elm = ResetTargetElement;
    clear_file();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(plan); i++) begin
      if (plan[i].tgt_grp != tgt_grp || plan[i].tgt_elm != tgt_elm)
        write_tag(plan[i].tgt_grp, plan[i].tgt_elm);
      build_case(plan[i]);
      send_file('{1'b1, plan[i].status, plan[i].offset});
    end

    for (int ph = 0; ph < 3; ph++) begin
      in_gap_pct = in_gaps[ph];
      out_gap_pct = out_gaps[ph];
      write_tag(16'($urandom), 16'($urandom));
      goal = sent_count + PhaseBytes;
      while (sent_count < goal) begin
        build_random_file();
        send_file('0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: too long without any accepted request, result or write
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
